// File: rtl/slp_pkg.sv
// ----------------------------------------------------------------------------
// slp_pkg
// Shared types and constants for the skyline bottom-left placer.
// ----------------------------------------------------------------------------
package slp_pkg;

  localparam int DIM_W      = 11;
  localparam int POS_X_W    = 10;
  localparam int POS_Y_W    = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 2;

  typedef logic [DIM_W-1:0]      dim_t;
  typedef logic [POS_X_W-1:0]    pos_x_t;
  typedef logic [POS_Y_W-1:0]    pos_y_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

  // register map
  localparam cfg_addr_t CFG_SIDE_ADDR = 2'd0;
  localparam dim_t      SIDE_RESET    = 11'd1024;

  // scan unit status towards the sequencer
  typedef struct packed {
    logic done;
    logic found;
  } scan_stat_t;

endpackage

// File: rtl/slp_in_if.sv
// ----------------------------------------------------------------------------
// slp_in_if
// Block request channel: unrotated width and height of one block.
// ----------------------------------------------------------------------------
interface slp_in_if;
  import slp_pkg::*;

  logic valid;
  logic ready;
  dim_t block_width;
  dim_t block_height;

  modport source (output valid, block_width, block_height, input ready);
  modport sink   (input valid, block_width, block_height, output ready);

endinterface

// File: rtl/slp_out_if.sv
// ----------------------------------------------------------------------------
// slp_out_if
// Placement result channel: one beat per block request.
// ----------------------------------------------------------------------------
interface slp_out_if;
  import slp_pkg::*;

  logic   valid;
  logic   ready;
  logic   placed_ok;
  logic   rotated;
  pos_x_t pos_x;
  pos_y_t pos_y;
  dim_t   span_w;
  dim_t   span_h;
  logic   exceeds_side;
  logic   overflow_seen;

  modport source (output valid, placed_ok, rotated, pos_x, pos_y, span_w, span_h,
                  exceeds_side, overflow_seen, input ready);
  modport sink   (input valid, placed_ok, rotated, pos_x, pos_y, span_w, span_h,
                  exceeds_side, overflow_seen, output ready);

endinterface

// File: rtl/skyline_bottom_left_placer.sv
// ----------------------------------------------------------------------------
// skyline_bottom_left_placer
// Skyline bottom-left strip packer with one column-height RAM and a scan unit.
// ----------------------------------------------------------------------------
// after reset a clearing pass zeroes all MAX_SIDE entries of the height RAM,
// with in_bus.ready low; configuration writes are taken throughout.
// one block at a time: each orientation (only one for a square block) scans
// x = 0.. with one RAM read per spanned column plus a compare for each x,
// stopping early at height 0; all reads go through the single read port.
// then the spanned columns are raised and the result is registered once the
// output is free; a new request is taken only after that, back in idle.
// ----------------------------------------------------------------------------
module skyline_bottom_left_placer #(
  parameter int MAX_SIDE    = 1024,
  parameter int HEIGHT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  slp_in_if.sink             in_bus,
  slp_out_if.source          out_bus,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  slp_pkg::cfg_addr_t cfg_paddr,
  input  slp_pkg::cfg_data_t cfg_pwdata,
  output slp_pkg::cfg_data_t cfg_prdata,
  output logic               cfg_pready
);
  import slp_pkg::*;

  localparam int AW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int CW    = $clog2(MAX_SIDE + 1);
  localparam int SW    = ((CW > DIM_W) ? CW : DIM_W) + 1;
  localparam int TOP_W = ((HEIGHT_BITS > DIM_W) ? HEIGHT_BITS : DIM_W) + 1;
  localparam int EW    = (TOP_W > SW) ? TOP_W : SW;

  localparam logic [2:0] T_CLR    = 3'd0;
  localparam logic [2:0] T_IDLE   = 3'd1;
  localparam logic [2:0] T_SCAN_A = 3'd2;
  localparam logic [2:0] T_SCAN_B = 3'd3;
  localparam logic [2:0] T_PICK   = 3'd4;
  localparam logic [2:0] T_RAISE  = 3'd5;
  localparam logic [2:0] T_OUT    = 3'd6;

  logic [2:0]             state_r, state_nxt;
  dim_t                   bw_r, bw_nxt;
  dim_t                   bh_r, bh_nxt;
  logic                   start_r, start_nxt;
  dim_t                   scan_w_r, scan_w_nxt;
  logic                   has_a_r, has_a_nxt;
  logic                   has_b_r, has_b_nxt;
  logic [SW-1:0]          ax_r, ax_nxt;
  logic [SW-1:0]          rx_r, rx_nxt;
  logic [HEIGHT_BITS-1:0] ay_r, ay_nxt;
  logic [HEIGHT_BITS-1:0] ry_r, ry_nxt;
  logic [SW-1:0]          cx_r, cx_nxt;
  logic [HEIGHT_BITS-1:0] cy_r, cy_nxt;
  dim_t                   cw_r, cw_nxt;
  dim_t                   ch_r, ch_nxt;
  logic                   rot_r, rot_nxt;
  logic                   ok_r, ok_nxt;
  logic [TOP_W-1:0]       top_r, top_nxt;
  logic [SW-1:0]          k_r, k_nxt;
  logic                   flag_r, flag_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   o_ok_r, o_ok_nxt;
  logic                   o_rot_r, o_rot_nxt;
  pos_x_t                 o_x_r, o_x_nxt;
  pos_y_t                 o_y_r, o_y_nxt;
  dim_t                   o_w_r, o_w_nxt;
  dim_t                   o_h_r, o_h_nxt;
  logic                   o_exc_r, o_exc_nxt;
  logic                   o_flag_r, o_flag_nxt;

  dim_t                   side_length;
  logic [SW-1:0]          cap;
  scan_stat_t             scan_stat;
  logic [SW-1:0]          scan_x;
  logic [HEIGHT_BITS-1:0] scan_y;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic [HEIGHT_BITS-1:0] rd_data;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [HEIGHT_BITS-1:0] wr_data;
  logic [HEIGHT_BITS-1:0] top_sat;
  logic [SW-1:0]          raise_end;
  logic                   sel_a;
  logic                   exceeds;
  logic                   out_free;

  slp_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (cfg_psel),
    .penable     (cfg_penable),
    .pwrite      (cfg_pwrite),
    .paddr       (cfg_paddr),
    .pwdata      (cfg_pwdata),
    .prdata      (cfg_prdata),
    .pready      (cfg_pready),
    .side_length (side_length)
  );

  assign cap = (SW'(side_length) < SW'(MAX_SIDE)) ? SW'(side_length) : SW'(MAX_SIDE);

  slp_scan #(
    .MAX_SIDE    (MAX_SIDE),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start_r),
    .scan_w  (scan_w_r),
    .cap     (cap),
    .stat    (scan_stat),
    .best_x  (scan_x),
    .best_y  (scan_y),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  slp_ram #(
    .WIDTH (HEIGHT_BITS),
    .DEPTH (MAX_SIDE)
  ) u_heights (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // saturate the new column top at the height range
  assign top_sat   = (top_r > TOP_W'({HEIGHT_BITS{1'b1}})) ? {HEIGHT_BITS{1'b1}}
                                                          : top_r[HEIGHT_BITS-1:0];
  assign raise_end = cx_r + SW'(cw_r);

  assign wr_en   = (state_r == T_CLR) || ((state_r == T_RAISE) && (k_r != raise_end));
  assign wr_addr = k_r[AW-1:0];
  assign wr_data = (state_r == T_CLR) ? '0 : top_sat;

  // unrotated wins unless rotated is lower, or equally low and strictly left
  assign sel_a = has_a_r && (!has_b_r || (ay_r < ry_r) || ((ay_r == ry_r) && (ax_r <= rx_r)));

  assign exceeds  = ok_r && ((EW'(raise_end) > EW'(cap)) || (EW'(top_r) > EW'(cap)));
  assign out_free = !out_valid_r || out_bus.ready;

  assign in_bus.ready          = (state_r == T_IDLE);
  assign out_bus.valid         = out_valid_r;
  assign out_bus.placed_ok     = o_ok_r;
  assign out_bus.rotated       = o_rot_r;
  assign out_bus.pos_x         = o_x_r;
  assign out_bus.pos_y         = o_y_r;
  assign out_bus.span_w        = o_w_r;
  assign out_bus.span_h        = o_h_r;
  assign out_bus.exceeds_side  = o_exc_r;
  assign out_bus.overflow_seen = o_flag_r;

  always_comb begin
    state_nxt     = state_r;
    bw_nxt        = bw_r;
    bh_nxt        = bh_r;
    start_nxt     = 1'b0;
    scan_w_nxt    = scan_w_r;
    has_a_nxt     = has_a_r;
    has_b_nxt     = has_b_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    rx_nxt        = rx_r;
    ry_nxt        = ry_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    cw_nxt        = cw_r;
    ch_nxt        = ch_r;
    rot_nxt       = rot_r;
    ok_nxt        = ok_r;
    top_nxt       = top_r;
    k_nxt         = k_r;
    flag_nxt      = flag_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    o_ok_nxt      = o_ok_r;
    o_rot_nxt     = o_rot_r;
    o_x_nxt       = o_x_r;
    o_y_nxt       = o_y_r;
    o_w_nxt       = o_w_r;
    o_h_nxt       = o_h_r;
    o_exc_nxt     = o_exc_r;
    o_flag_nxt    = o_flag_r;
    unique case (state_r)
      T_CLR: begin
        if (k_r == SW'(MAX_SIDE - 1)) begin
          state_nxt = T_IDLE;
        end else begin
          k_nxt = k_r + SW'(1);
        end
      end
      T_IDLE: begin
        if (in_bus.valid) begin
          bw_nxt     = in_bus.block_width;
          bh_nxt     = in_bus.block_height;
          scan_w_nxt = in_bus.block_width;
          start_nxt  = 1'b1;
          state_nxt  = T_SCAN_A;
        end
      end
      T_SCAN_A: begin
        if (scan_stat.done) begin
          has_a_nxt = scan_stat.found;
          ax_nxt    = scan_x;
          ay_nxt    = scan_y;
          has_b_nxt = 1'b0;
          if (bw_r != bh_r) begin
            scan_w_nxt = bh_r;
            start_nxt  = 1'b1;
            state_nxt  = T_SCAN_B;
          end else begin
            state_nxt = T_PICK;
          end
        end
      end
      T_SCAN_B: begin
        if (scan_stat.done) begin
          has_b_nxt = scan_stat.found;
          rx_nxt    = scan_x;
          ry_nxt    = scan_y;
          state_nxt = T_PICK;
        end
      end
      T_PICK: begin
        if (sel_a) begin
          cx_nxt  = ax_r;
          cy_nxt  = ay_r;
          cw_nxt  = bw_r;
          ch_nxt  = bh_r;
          rot_nxt = 1'b0;
          ok_nxt  = 1'b1;
        end else if (has_b_r) begin
          cx_nxt  = rx_r;
          cy_nxt  = ry_r;
          cw_nxt  = bh_r;
          ch_nxt  = bw_r;
          rot_nxt = 1'b1;
          ok_nxt  = 1'b1;
        end else begin
          // fits nowhere: zero span so nothing is raised
          cx_nxt  = '0;
          cy_nxt  = '0;
          cw_nxt  = '0;
          ch_nxt  = '0;
          rot_nxt = 1'b0;
          ok_nxt  = 1'b0;
        end
        top_nxt   = TOP_W'(cy_nxt) + TOP_W'(ch_nxt);
        k_nxt     = cx_nxt;
        state_nxt = T_RAISE;
      end
      T_RAISE: begin
        if (k_r == raise_end) begin
          state_nxt = T_OUT;
        end else begin
          k_nxt = k_r + SW'(1);
        end
      end
      T_OUT: begin
        if (out_free) begin
          flag_nxt      = flag_r || exceeds;
          out_valid_nxt = 1'b1;
          o_ok_nxt      = ok_r;
          o_rot_nxt     = rot_r;
          o_x_nxt       = POS_X_W'(cx_r);
          o_y_nxt       = POS_Y_W'(cy_r);
          o_w_nxt       = cw_r;
          o_h_nxt       = ch_r;
          o_exc_nxt     = exceeds;
          o_flag_nxt    = flag_r || exceeds;
          state_nxt     = T_IDLE;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_CLR;
      k_r         <= '0;
      start_r     <= 1'b0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      start_r     <= start_nxt;
      flag_r      <= flag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bw_r     <= bw_nxt;
    bh_r     <= bh_nxt;
    scan_w_r <= scan_w_nxt;
    has_a_r  <= has_a_nxt;
    has_b_r  <= has_b_nxt;
    ax_r     <= ax_nxt;
    ay_r     <= ay_nxt;
    rx_r     <= rx_nxt;
    ry_r     <= ry_nxt;
    cx_r     <= cx_nxt;
    cy_r     <= cy_nxt;
    cw_r     <= cw_nxt;
    ch_r     <= ch_nxt;
    rot_r    <= rot_nxt;
    ok_r     <= ok_nxt;
    top_r    <= top_nxt;
    o_ok_r   <= o_ok_nxt;
    o_rot_r  <= o_rot_nxt;
    o_x_r    <= o_x_nxt;
    o_y_r    <= o_y_nxt;
    o_w_r    <= o_w_nxt;
    o_h_r    <= o_h_nxt;
    o_exc_r  <= o_exc_nxt;
    o_flag_r <= o_flag_nxt;
  end

endmodule

// File: rtl/slp_ram.sv
// ----------------------------------------------------------------------------
// slp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/slp_cfg.sv
// ----------------------------------------------------------------------------
// slp_cfg
// APB register slice holding the strip side length.
// ----------------------------------------------------------------------------
module slp_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  slp_pkg::cfg_addr_t paddr,
  input  slp_pkg::cfg_data_t pwdata,
  output slp_pkg::cfg_data_t prdata,
  output logic               pready,
  output slp_pkg::dim_t      side_length
);
  import slp_pkg::*;

  dim_t side_r;
  logic wr_en;

  assign pready      = 1'b1;
  assign wr_en       = psel && penable && pwrite && (paddr == CFG_SIDE_ADDR);
  assign side_length = side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SIDE_RESET;
    end else if (wr_en) begin
      side_r <= pwdata[DIM_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == CFG_SIDE_ADDR) begin
      prdata = CFG_DATA_W'(side_r);
    end
  end

endmodule

// File: rtl/slp_scan.sv
// ----------------------------------------------------------------------------
// slp_scan
// Skyline scan unit: finds the lowest, then leftmost, spot for one width.
// ----------------------------------------------------------------------------
module slp_scan #(
  parameter int MAX_SIDE    = 1024,
  parameter int HEIGHT_BITS = 16,
  localparam int AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1,
  localparam int CW = $clog2(MAX_SIDE + 1),
  localparam int SW = ((CW > slp_pkg::DIM_W) ? CW : slp_pkg::DIM_W) + 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  slp_pkg::dim_t          scan_w,
  input  logic [SW-1:0]          cap,
  output slp_pkg::scan_stat_t    stat,
  output logic [SW-1:0]          best_x,
  output logic [HEIGHT_BITS-1:0] best_y,
  output logic                   rd_en,
  output logic [AW-1:0]          rd_addr,
  input  logic [HEIGHT_BITS-1:0] rd_data
);
  import slp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [SW-1:0]          x_r, x_nxt;
  logic [SW-1:0]          k_r, k_nxt;
  logic [SW-1:0]          w_r, w_nxt;
  logic [SW-1:0]          cap_r, cap_nxt;
  logic [HEIGHT_BITS-1:0] acc_r, acc_nxt;
  logic [HEIGHT_BITS-1:0] by_r, by_nxt;
  logic [SW-1:0]          bx_r, bx_nxt;
  logic                   rd_v_r, rd_v_nxt;
  logic                   found_r, found_nxt;
  logic                   done_r, done_nxt;

  logic [HEIGHT_BITS-1:0] win_max;
  logic [HEIGHT_BITS-1:0] new_by;
  logic                   better;
  logic [SW-1:0]          w_in;

  // the shared compare unit: running max over the window, then min over windows
  assign win_max = (rd_v_r && (rd_data > acc_r)) ? rd_data : acc_r;
  assign better  = !found_r || (win_max < by_r);
  assign new_by  = better ? win_max : by_r;
  assign w_in    = SW'(scan_w);

  assign rd_addr = k_r[AW-1:0];
  assign rd_en   = (state_r == S_RD);

  assign stat.done  = done_r;
  assign stat.found = found_r;
  assign best_x     = bx_r;
  assign best_y     = by_r;

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    k_nxt     = k_r;
    w_nxt     = w_r;
    cap_nxt   = cap_r;
    acc_nxt   = acc_r;
    by_nxt    = by_r;
    bx_nxt    = bx_r;
    found_nxt = found_r;
    done_nxt  = 1'b0;
    rd_v_nxt  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          w_nxt   = w_in;
          cap_nxt = cap;
          x_nxt   = '0;
          k_nxt   = '0;
          acc_nxt = '0;
          bx_nxt  = '0;
          by_nxt  = '0;
          if (w_in == '0) begin
            // zero width sits at the origin and touches nothing
            found_nxt = 1'b1;
            done_nxt  = 1'b1;
          end else if (w_in > cap) begin
            found_nxt = 1'b0;
            done_nxt  = 1'b1;
          end else begin
            found_nxt = 1'b0;
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        rd_v_nxt = 1'b1;
        acc_nxt  = win_max;
        if (k_r == x_r + w_r - SW'(1)) begin
          state_nxt = S_EVAL;
        end else begin
          k_nxt = k_r + SW'(1);
        end
      end
      S_EVAL: begin
        if (better) begin
          bx_nxt    = x_r;
          by_nxt    = win_max;
          found_nxt = 1'b1;
        end
        if ((new_by == '0) || (x_r + w_r == cap_r)) begin
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          x_nxt     = x_r + SW'(1);
          k_nxt     = x_r + SW'(1);
          acc_nxt   = '0;
          state_nxt = S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      rd_v_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      rd_v_r  <= rd_v_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    k_r   <= k_nxt;
    w_r   <= w_nxt;
    cap_r <= cap_nxt;
    acc_r <= acc_nxt;
    by_r  <= by_nxt;
    bx_r  <= bx_nxt;
  end

endmodule

// File: sim/skyline_bottom_left_placer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// skyline_bottom_left_placer_test
// Self-checking bench for the skyline placer. Every accepted block request is
// run through a skyline kept in the bench, so each result beat is predicted
// and compared field by field. The run covers strip width changes, random
// idling on both channels, a long receiver hold-off and height saturation.
// ----------------------------------------------------------------------------
module skyline_bottom_left_placer_test;
  import slp_pkg::*;

  localparam int MAX_SIDE      = 1024;
  localparam int HEIGHT_BITS   = 16;
  localparam int HEIGHT_MAX    = (1 << HEIGHT_BITS) - 1;
  localparam int STALL_LIMIT   = 100000;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_BLOCKS  = 10;
  localparam int FILL_BLOCKS   = 12;
  localparam int HOLD_OFF_LEN  = 400;

  typedef struct packed {
    logic   placed_ok;
    logic   rotated;
    pos_x_t pos_x;
    pos_y_t pos_y;
    dim_t   span_w;
    dim_t   span_h;
    logic   exceeds_side;
    logic   overflow_seen;
  } placement_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      cfg_psel;
  logic      cfg_penable;
  logic      cfg_pwrite;
  cfg_addr_t cfg_paddr;
  cfg_data_t cfg_pwdata;
  cfg_data_t cfg_prdata;
  logic      cfg_pready;

  slp_in_if  in_bus ();
  slp_out_if out_bus ();

  skyline_bottom_left_placer #(
    .MAX_SIDE    (MAX_SIDE),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_bus),
    .out_bus     (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // bench copy of the skyline and the sticky overflow
  logic [HEIGHT_BITS-1:0] skyline [MAX_SIDE];
  bit                     overflow_sticky;
  int unsigned            strip_width;
  placement_t             placement_q [$];
  placement_t             want;

  int errors         = 0;
  bit idling_on      = 1'b1;
  int hold_off_req   = 0;
  int ready_low_left = 0;
  int idle_cycles    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // lowest, then leftmost, spot for a span of width w
  function automatic bit find_lowest(input int unsigned w, output int unsigned bx,
                                     output int unsigned by);
    int unsigned x;
    int unsigned k;
    int unsigned y;
    bit found;
    found = 1'b0;
    bx = 0;
    by = 0;
    if (w > strip_width) return 1'b0;
    for (x = 0; x + w <= strip_width; x++) begin
      y = 0;
      for (k = x; k < x + w; k++)
        if (skyline[k] > y) y = skyline[k];
      if (!found || y < by) begin
        bx = x;
        by = y;
        found = 1'b1;
      end
      if (by == 0) break;
    end
    return found;
  endfunction

  task automatic predict_placement(input dim_t w, input dim_t h);
    int unsigned ax, ay;
    int unsigned rx, ry;
    int unsigned cx, cy, cw, ch;
    int unsigned block_top, k;
    bit has_a, has_b;
    placement_t p;
    rx = 0;
    ry = 0;
    p = '0;
    has_a = find_lowest(w, ax, ay);
    has_b = (w != h) && find_lowest(h, rx, ry);
    if (has_a && (!has_b || ay < ry || (ay == ry && ax <= rx))) begin
      cx = ax; cy = ay; cw = w; ch = h;
      p.placed_ok = 1'b1;
    end else if (has_b) begin
      cx = rx; cy = ry; cw = h; ch = w;
      p.placed_ok = 1'b1;
      p.rotated   = 1'b1;
    end
    if (p.placed_ok) begin
      block_top = cy + ch;
      for (k = cx; k < cx + cw && k < MAX_SIDE; k++)
        skyline[k] = (block_top > HEIGHT_MAX) ? HEIGHT_MAX[HEIGHT_BITS-1:0]
                                              : block_top[HEIGHT_BITS-1:0];
      p.exceeds_side = (cx + cw > strip_width) || (block_top > strip_width);
      if (p.exceeds_side) overflow_sticky = 1'b1;
      p.pos_x  = pos_x_t'(cx);
      p.pos_y  = pos_y_t'(cy);
      p.span_w = dim_t'(cw);
      p.span_h = dim_t'(ch);
    end
    p.overflow_seen = overflow_sticky;
    placement_q.push_back(p);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // result beats against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (placement_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, actual ok=%0d x=%0d y=%0d",
                 $time, out_bus.placed_ok, out_bus.pos_x, out_bus.pos_y);
        errors++;
      end else begin
        want = placement_q.pop_front();
        check_field("placed_ok", want.placed_ok, out_bus.placed_ok);
        check_field("rotated", want.rotated, out_bus.rotated);
        check_field("pos_x", want.pos_x, out_bus.pos_x);
        check_field("pos_y", want.pos_y, out_bus.pos_y);
        check_field("span_w", want.span_w, out_bus.span_w);
        check_field("span_h", want.span_h, out_bus.span_h);
        check_field("exceeds_side", want.exceeds_side, out_bus.exceeds_side);
        check_field("overflow_seen", want.overflow_seen, out_bus.overflow_seen);
      end
    end
  end

  // receiver: long hold-off on request, else random stall bursts
  always @(posedge clk) begin
    if (hold_off_req > 0) begin
      ready_low_left = hold_off_req;
      hold_off_req = 0;
    end
    if (ready_low_left > 0) begin
      out_bus.ready <= 1'b0;
      ready_low_left--;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      out_bus.ready <= 1'b0;
      ready_low_left = $urandom_range(0, 9);
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, idle_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // valid stays high after a beat so requests can go back to back
  task automatic send_block(input dim_t w, input dim_t h);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.block_width  <= w;
    in_bus.block_height <= h;
    do @(posedge clk); while (!in_bus.ready);
    predict_placement(w, h);
  endtask

  task automatic wait_results_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (placement_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_transfer(input bit is_write, input cfg_data_t wdata,
                              output cfg_data_t rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= is_write;
    cfg_paddr   <= CFG_SIDE_ADDR;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_strip_side(input int unsigned side);
    cfg_data_t rdata;
    int unsigned field;
    field = side & 'h7FF;
    cfg_transfer(1'b1, cfg_data_t'(side), rdata);
    strip_width = (field < MAX_SIDE) ? field : MAX_SIDE;
    cfg_transfer(1'b0, '0, rdata);
    check_field("side_length readback", field, rdata);
  endtask

  // mostly fitting shapes, some that fit one way only and some that never fit
  function automatic void pick_block(input int unsigned cap, output dim_t w, output dim_t h);
    dim_t t;
    case ($urandom_range(0, 15))
      0: begin
        w = '0;
        h = dim_t'($urandom_range(0, cap));
      end
      1: begin
        w = dim_t'($urandom_range(cap + 1, 2047));
        h = dim_t'($urandom_range(1, cap));
      end
      2: begin
        w = dim_t'($urandom_range(cap + 1, 2047));
        h = dim_t'($urandom_range(cap + 1, 2047));
      end
      3: begin
        w = dim_t'($urandom_range(1, cap));
        h = w;
      end
      default: begin
        w = dim_t'($urandom_range(1, (cap + 1) / 2));
        h = dim_t'($urandom_range(1, cap));
      end
    endcase
    if ($urandom_range(0, 1) == 1) begin
      t = w;
      w = h;
      h = t;
    end
  endfunction

  task automatic test_register_reset();
    cfg_data_t rdata;
    cfg_transfer(1'b0, '0, rdata);
    check_field("side_length after reset", SIDE_RESET, rdata);
  endtask

  task automatic test_full_width();
    set_strip_side(1024);
    send_block(11'd0, 11'd0);
    send_block(11'd0, 11'd5);
    send_block(11'd1024, 11'd1);    // one row across the whole strip
    send_block(11'd2047, 11'd3);    // only turned on its side does it fit
    send_block(11'd2047, 11'd2047); // fits in neither orientation
    send_block(11'd1, 11'd1024);
    wait_results_drained();
  endtask

  task automatic test_side_extremes();
    set_strip_side(0);              // zero strip: only zero-width shapes go in
    send_block(11'd3, 11'd4);
    send_block(11'd0, 11'd2);
    send_block(11'd1, 11'd0);
    wait_results_drained();
    set_strip_side(1);
    send_block(11'd1, 11'd5);
    wait_results_drained();
    set_strip_side(2047);           // clamps to the full strip
    send_block(11'd2, 11'd2);
    wait_results_drained();
  endtask

  task automatic test_orientation();
    set_strip_side(16);
    send_block(11'd3, 11'd1);
    send_block(11'd1, 11'd3);
    send_block(11'd16, 11'd2);
    send_block(11'd2, 11'd16);
    send_block(11'd17, 11'd1);
    send_block(11'd5, 11'd5);
    wait_results_drained();
  endtask

  task automatic test_random_mix();
    int unsigned side;
    int phase, n;
    dim_t w, h;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      side = $urandom_range(2, 48);
      set_strip_side(side);
      idling_on = (phase != 2);
      for (n = 0; n < PHASE_BLOCKS; n++) begin
        pick_block(side, w, h);
        send_block(w, h);
      end
      wait_results_drained();
    end
  endtask

  task automatic test_backpressure();
    int unsigned side;
    int n;
    dim_t w, h;
    side = $urandom_range(8, 32);
    set_strip_side(side);
    idling_on = 1'b0;
    hold_off_req = HOLD_OFF_LEN;
    for (n = 0; n < FILL_BLOCKS; n++) begin
      pick_block(side, w, h);
      send_block(w, h);
    end
    wait_results_drained();
  endtask

  task automatic test_saturation();
    set_strip_side(1);
    idling_on = 1'b0;
    while (skyline[0] != HEIGHT_MAX) send_block(11'd1, 11'd2047);
    send_block(11'd1, 11'd2047);    // column stays pinned at the ceiling
    send_block(11'd0, 11'd7);
    wait_results_drained();
  endtask

  initial begin
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.block_width  = '0;
    in_bus.block_height = '0;
    out_bus.ready       = 1'b0;
    cfg_psel            = 1'b0;
    cfg_penable         = 1'b0;
    cfg_pwrite          = 1'b0;
    cfg_paddr           = CFG_SIDE_ADDR;
    cfg_pwdata          = '0;
    overflow_sticky     = 1'b0;
    strip_width         = MAX_SIDE;
    foreach (skyline[i]) skyline[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_register_reset();
    test_full_width();
    test_side_extremes();
    test_orientation();
    test_random_mix();
    test_backpressure();
    test_saturation();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
